// ===== hdl/sed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder package
// Phase codes, character constants, escape tables and the step record types.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int LEN_W       = 16;
  localparam logic [LEN_W-1:0] LEN_MAX = (LENGTH_BITS >= 16) ? 16'hFFFF :
      LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TEXT = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEXA = 3'd3;
  localparam logic [2:0] PH_HEXB = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0]       phase;
    logic             quoted;
    logic [3:0]       hex_high;
    logic [LEN_W-1:0] byte_count;
  } sed_state_t;

  typedef struct packed {
    sed_state_t       state;
    logic             emit;
    logic [7:0]       ch;
    logic             done;
    logic [LEN_W-1:0] len;
  } sed_step_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h30: v = 8'd0;
      8'h61: v = 8'd7;
      8'h62: v = 8'd8;
      8'h66: v = 8'd12;
      8'h6E: v = 8'd10;
      8'h72: v = 8'd13;
      8'h74: v = 8'd9;
      8'h76: v = 8'd11;
      8'h73: v = CH_SPACE;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sed_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder step
// Next state and optional result for one character against the current state.
// ----------------------------------------------------------------------------
module sed_step (
  input  wire logic [7:0]         c,
  input  wire logic               start,
  input  wire sed_pkg::sed_state_t cur,
  output sed_pkg::sed_step_t      res
);
  import sed_pkg::*;

  logic [2:0]       eff_phase;
  logic             eff_quoted;
  logic [LEN_W-1:0] eff_cnt;
  logic             proceed;
  logic             term_nul;
  logic [7:0]       byte_val;
  logic             byte_emit;

  always_comb begin
    eff_phase  = start ? PH_TEXT : cur.phase;
    eff_quoted = start ? (c == CH_DQ) : cur.quoted;
    eff_cnt    = start ? '0 : cur.byte_count;
    proceed    = start ? (c != CH_DQ) : (cur.phase != PH_IDLE);
    term_nul   = !eff_quoted && (c == CH_NUL);

    res.state.phase      = eff_phase;
    res.state.quoted     = eff_quoted;
    res.state.hex_high   = start ? 4'd0 : cur.hex_high;
    res.state.byte_count = eff_cnt;
    res.emit             = 1'b0;
    res.ch               = '0;
    res.done             = 1'b0;
    res.len              = '0;
    byte_emit            = 1'b0;
    byte_val             = c;

    if (proceed) begin
      case (eff_phase)
        PH_TEXT: begin
          if ((eff_quoted && c == CH_DQ) || term_nul) begin
            res.done = 1'b1;
          end else if (c == CH_BSL) begin
            res.state.phase = PH_ESC;
          end else begin
            byte_emit = 1'b1;
          end
        end
        PH_ESC: begin
          if (term_nul) begin
            res.done = 1'b1;
          end else if (c == CH_X) begin
            res.state.phase = PH_HEXA;
          end else begin
            res.state.phase = PH_TEXT;
            byte_val        = escape_value(c);
            byte_emit       = 1'b1;
          end
        end
        PH_HEXA: begin
          if (term_nul) begin
            res.done = 1'b1;
          end else begin
            res.state.hex_high = hex_value(c);
            res.state.phase    = PH_HEXB;
          end
        end
        PH_HEXB: begin
          if (term_nul) begin
            res.done = 1'b1;
          end else begin
            res.state.phase = PH_TEXT;
            byte_val        = {cur.hex_high, hex_value(c)};
            byte_emit       = 1'b1;
          end
        end
        default: begin
          res.state.phase = PH_IDLE;
        end
      endcase
    end

    if (res.done) begin
      res.emit        = 1'b1;
      res.len         = eff_cnt;
      res.state.phase = PH_IDLE;
    end else if (byte_emit) begin
      res.emit = 1'b1;
      res.ch   = byte_val;
      if (eff_cnt < LEN_MAX) begin
        res.state.byte_count = eff_cnt + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/string_escape_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder
// Decodes a C-style string literal one raw character per request.
// Each request is held in the input stage register, decoded by the step logic and registered into the result register.
// Throughput: one request per cycle; stalls only while the result is held.
// The decode state is read by the combinational step logic and updated when the input stage advances.
// Reset (rst, synchronous) empties both stages and returns to idle.
// ----------------------------------------------------------------------------
module string_escape_decoder (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic [7:0]                in_char,
  input  wire logic                      start_req,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic [7:0]                out_char,
  output      logic                      done_res,
  output      logic [sed_pkg::LEN_W-1:0] decoded_length
);
  import sed_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_start;
  sed_state_t state;
  sed_step_t  step;
  logic       advance;

  sed_step u_step (
    .c     (s1_char),
    .start (s1_start),
    .cur   (state),
    .res   (step)
  );

  assign advance  = s1_valid && (!step.emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      state.phase      <= PH_IDLE;
      state.quoted     <= 1'b0;
      state.hex_high   <= '0;
      state.byte_count <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        state <= step.state;
      end
      if (advance && step.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char  <= in_char;
      s1_start <= start_req;
    end
    if (advance && step.emit) begin
      out_char       <= step.ch;
      done_res       <= step.done;
      decoded_length <= step.len;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("result or input stage valid after reset");
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !advance |=> s1_valid)
    else $error("held request dropped");
  a_done_char: assert property (@(posedge clk) disable iff (rst)
      out_valid && done_res |-> out_char == '0)
    else $error("done result with non-zero character");
  a_byte_len: assert property (@(posedge clk) disable iff (rst)
      out_valid && !done_res |-> decoded_length == '0)
    else $error("byte result with non-zero length");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String escape decoder testbench
// Feeds raw literal characters one request at a time and predicts every
// decoded byte and terminator result with a local decoder model. Each
// result is checked field by field in order of arrival. Covers quoted and
// unquoted literals, all escapes, hex escapes and abandoned literals.
// ----------------------------------------------------------------------------
module tb;
  import sed_pkg::*;

  localparam int ITEM_GOAL     = 1700;
  localparam int TAIL_ITEMS    = 500;
  localparam int TAIL_LITERALS = 30;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LB   = 8'h62;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_LN   = 8'h6E;
  localparam logic [7:0] CH_LR   = 8'h72;
  localparam logic [7:0] CH_LS   = 8'h73;
  localparam logic [7:0] CH_LT   = 8'h74;
  localparam logic [7:0] CH_LV   = 8'h76;
  localparam logic [7:0] CH_SQ   = 8'h27;

  localparam logic [7:0] CC_BEL = 8'h07;
  localparam logic [7:0] CC_BS  = 8'h08;
  localparam logic [7:0] CC_HT  = 8'h09;
  localparam logic [7:0] CC_LF  = 8'h0A;
  localparam logic [7:0] CC_VT  = 8'h0B;
  localparam logic [7:0] CC_FF  = 8'h0C;
  localparam logic [7:0] CC_CR  = 8'h0D;

  typedef struct packed {
    logic [7:0]       ch;
    logic             done;
    logic [LEN_W-1:0] len;
  } decoded_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [7:0]       in_char   = 8'h00;
  logic             start_req = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_char;
  logic             done_res;
  logic [LEN_W-1:0] decoded_length;

  decoded_t decoded_q[$];

  logic [2:0]       lit_phase  = PH_IDLE;
  logic             lit_quoted = 1'b0;
  logic [3:0]       lit_hex_hi = 4'd0;
  logic [LEN_W-1:0] lit_count  = '0;

  int errors     = 0;
  int n_items    = 0;
  int n_literals = 0;
  int n_checked  = 0;
  int quiet      = 0;
  int hold_left  = 0;
  bit calm       = 1'b0;

  string_escape_decoder uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .start_req      (start_req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .done_res       (done_res),
    .decoded_length (decoded_length)
  );

  always #10 clk = ~clk;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    case (c)
      CH_ZERO: return CH_NUL;
      CH_LA:   return CC_BEL;
      CH_LB:   return CC_BS;
      CH_LF:   return CC_FF;
      CH_LN:   return CC_LF;
      CH_LR:   return CC_CR;
      CH_LT:   return CC_HT;
      CH_LV:   return CC_VT;
      CH_LS:   return CH_SPACE;
      default: return c;
    endcase
  endfunction

  task automatic decode_step(input logic [7:0] c, input logic s, output bit emits,
                             output decoded_t r, output bit ignored);
    logic [7:0] b;
    bit         put;
    emits   = 1'b0;
    ignored = 1'b0;
    put     = 1'b0;
    b       = 8'h00;
    r       = '0;
    if (s) begin
      lit_quoted = 1'b0;
      lit_hex_hi = 4'd0;
      lit_count  = '0;
      lit_phase  = PH_TEXT;
      if (c == CH_DQ) begin
        lit_quoted = 1'b1;
        return;
      end
    end else if (lit_phase == PH_IDLE) begin
      ignored = 1'b1;
      return;
    end
    // unquoted NUL ends the literal in any phase, even mid-escape
    if ((!lit_quoted && c == CH_NUL) ||
        (lit_phase == PH_TEXT && lit_quoted && c == CH_DQ)) begin
      r.done    = 1'b1;
      r.len     = lit_count;
      lit_phase = PH_IDLE;
      emits     = 1'b1;
      return;
    end
    case (lit_phase)
      PH_TEXT: begin
        if (c == CH_BSL) lit_phase = PH_ESC;
        else begin
          b   = c;
          put = 1'b1;
        end
      end
      PH_ESC: begin
        if (c == CH_X) lit_phase = PH_HEXA;
        else begin
          lit_phase = PH_TEXT;
          b         = escape_byte(c);
          put       = 1'b1;
        end
      end
      PH_HEXA: begin
        lit_hex_hi = hex_digit(c);
        lit_phase  = PH_HEXB;
      end
      PH_HEXB: begin
        lit_phase = PH_TEXT;
        b         = {lit_hex_hi, hex_digit(c)};
        put       = 1'b1;
      end
      default: lit_phase = PH_IDLE;
    endcase
    if (put) begin
      if (lit_count < LEN_MAX) lit_count = lit_count + 1'b1;
      r.ch  = b;
      emits = 1'b1;
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic s);
    bit       emits;
    bit       ignored;
    decoded_t r;
    int       gap;
    in_valid  <= 1'b1;
    in_char   <= c;
    start_req <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_step(c, s, emits, r, ignored);
    if (emits) begin
      decoded_q.push_back(r);
      if (r.done) n_literals++;
    end
    if (!ignored) n_items++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
               what, n_checked, got, want);
  endtask

  always @(posedge clk) begin
    decoded_t w;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing pending, out_char", out_char, 0);
      end else begin
        w = decoded_q.pop_front();
        if (out_char != w.ch) report_mismatch("out_char", out_char, w.ch);
        if (done_res != w.done) report_mismatch("done_res", done_res, w.done);
        if (decoded_length != w.len)
          report_mismatch("decoded_length", decoded_length, w.len);
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("Watchdog: no request moved for %0d cycles", QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] body_byte(input bit quoted_lit);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_BSL || (quoted_lit ? (c == CH_DQ) : (c == CH_NUL)));
    return c;
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 12))
      0:       return CH_ZERO;
      1:       return CH_LA;
      2:       return CH_LB;
      3:       return CH_LF;
      4:       return CH_LN;
      5:       return CH_LR;
      6:       return CH_LT;
      7:       return CH_LV;
      8:       return CH_LS;
      9:       return CH_BSL;
      10:      return CH_SQ;
      11:      return CH_DQ;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_hex();
    case ($urandom_range(0, 4))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_LA + 8'($urandom_range(0, 5));
      2:       return CH_UA + 8'($urandom_range(0, 5));
      3:       return CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic rand_literal(input bit broken);
    bit quoted_lit;
    bit first;
    int len;
    int kind;
    quoted_lit = $urandom_range(0, 1);
    first      = 1'b1;
    if (quoted_lit) begin
      push_char(CH_DQ, 1'b1);
      first = 1'b0;
    end
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
    repeat (len) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        push_char(body_byte(quoted_lit), first);
      end else if (kind < 8) begin
        push_char(CH_BSL, first);
        push_char(pick_escape(), 1'b0);
      end else begin
        push_char(CH_BSL, first);
        push_char(CH_X, 1'b0);
        push_char(pick_hex(), 1'b0);
        push_char(pick_hex(), 1'b0);
      end
      first = 1'b0;
    end
    if (!broken) begin
      push_char(quoted_lit ? CH_DQ : CH_NUL, first);
    end else begin
      case ($urandom_range(0, 2))
        0: ; // left open; the next start abandons it
        1: begin
          push_char(CH_BSL, first);
          if ($urandom_range(0, 1)) begin
            push_char(CH_X, 1'b0);
            if ($urandom_range(0, 1)) push_char(pick_hex(), 1'b0);
          end
          push_char(CH_NUL, 1'b0);
        end
        default: push_char(8'($urandom_range(0, 255)), first);
      endcase
    end
  endtask

  task automatic test_directed_literals();
    push_char(8'h41, 1'b0);            // idle, ignored
    push_char(CH_DQ, 1'b1);            // quoted
    push_char(CH_NUL, 1'b0);           // NUL is plain data when quoted
    push_char(8'hFF, 1'b0);
    push_char(CH_BSL, 1'b0);           // quote inside hex adds nothing
    push_char(CH_X, 1'b0);
    push_char(CH_DQ, 1'b0);
    push_char(CH_UF, 1'b0);
    push_char(CH_BSL, 1'b0);           // space counts as zero
    push_char(CH_X, 1'b0);
    push_char(CH_SPACE, 1'b0);
    push_char(8'h37, 1'b0);
    push_char(CH_BSL, 1'b0);
    push_char(CH_DQ, 1'b0);
    push_char(CH_DQ, 1'b0);            // closing quote
    push_char(CH_BSL, 1'b1);           // unquoted, escape first
    push_char(CH_LA, 1'b0);
    push_char(CH_BSL, 1'b0);
    push_char(CH_X, 1'b0);
    push_char(CH_LF, 1'b0);
    push_char(8'h45, 1'b0);
    push_char(CH_BSL, 1'b0);           // NUL after backslash ends it
    push_char(CH_NUL, 1'b0);
    push_char(8'h51, 1'b1);            // abandoned by the next start
    push_char(8'h52, 1'b0);
    push_char(CH_DQ, 1'b1);
    push_char(CH_DQ, 1'b0);            // empty quoted literal
    push_char(CH_BSL, 1'b1);           // NUL in either hex position
    push_char(CH_X, 1'b0);
    push_char(CH_NUL, 1'b0);
    push_char(CH_BSL, 1'b1);
    push_char(CH_X, 1'b0);
    push_char(8'h31, 1'b0);
    push_char(CH_NUL, 1'b0);
  endtask

  task automatic test_random_literals(input int goal);
    int stop_at;
    int pick;
    stop_at = n_items + goal;
    while (n_items < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) rand_literal(1'b0);
      else if (pick < 18) rand_literal(1'b1);
      else begin
        repeat ($urandom_range(1, 4))
          push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic test_calm_tail();
    calm = 1'b1;
    repeat (TAIL_LITERALS) rand_literal($urandom_range(0, 9) == 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_literals();
    test_random_literals(ITEM_GOAL - TAIL_ITEMS);
    test_calm_tail();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d characters; %0d results checked over %0d terminated literals.",
             n_items, n_checked, n_literals);
    $display("Escapes, hex digits and abandoned literals exercised under random stalls.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sed_pkg.sv
hdl/sed_step.sv
hdl/string_escape_decoder.sv
bench/tb.sv
